FILE: rtl/bmhq_pkg.sv
// Shared types, sizes and codes of the binary min-heap request queue.
package bmhq_pkg;

    localparam int CAPACITY = 64;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int IDX_W    = ADDR_W + 2;
    localparam int ID_W     = 16;
    localparam int URG_W    = 3;
    localparam int OCC_W    = 7;

    localparam logic REQ_INSERT  = 1'b0;
    localparam logic REQ_EXTRACT = 1'b1;

    typedef enum logic [1:0] {
        ST_INSERTED  = 2'd0,
        ST_EXTRACTED = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    typedef struct packed {
        logic             req_type;
        logic [ID_W-1:0]  req_id;
        logic [URG_W-1:0] urgency;
    } t_req;

    typedef struct packed {
        t_status          status;
        logic [ID_W-1:0]  out_id;
        logic [URG_W-1:0] out_urgency;
        logic [OCC_W-1:0] occupancy;
    } t_result;

    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [URG_W-1:0] urg;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic    start_ins;
        logic    rd_parent;
        logic    wr_up;
        logic    wr_x;
        logic    rd_root;
        logic    rd_last;
        logic    ld_last;
        logic    rd_left;
        logic    rd_right;
        logic    wr_child;
        logic    finish;
        t_status code;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
        logic pos_zero;
        logic parent_greater;
        logic lc_out;
        logic child_smaller;
    } t_flags;

endpackage

FILE: rtl/bmhq_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module bmhq_ram #(
    parameter int WIDTH = 19,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/bmhq_dp.sv
// Datapath of the heap queue: entry count, moving entry, slot index, RAM and result register.
module bmhq_dp
    import bmhq_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_req    i_req,
    input  t_cmd    i_cmd,
    output t_flags  o_flags,
    output logic    o_strobe,
    output t_result o_result
);

    logic [CNT_W-1:0]  r_count, n_count;
    logic [ADDR_W-1:0] r_pos, n_pos;
    t_entry            r_x, n_x;
    t_entry            r_top, n_top;
    t_entry            r_left, n_left;
    logic              r_strobe, n_strobe;
    t_result           r_result, n_result;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    t_entry            ram_wdata;
    logic [ADDR_W-1:0] ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;
    t_entry            rdata;

    logic [ADDR_W-1:0] parent;
    logic [IDX_W-1:0]  lc;
    logic [IDX_W-1:0]  rc;
    logic [IDX_W-1:0]  count_x;
    logic              pick_right;
    t_entry            best;
    logic [ADDR_W-1:0] best_idx;

    bmhq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rdata   = t_entry'(ram_rdata);
    assign parent  = (r_pos - ADDR_W'(1)) >> 1;
    assign lc      = {1'b0, r_pos, 1'b1};
    assign rc      = lc + IDX_W'(1);
    assign count_x = IDX_W'(r_count);

    assign pick_right = (rc < count_x) && (rdata.urg < r_left.urg);
    assign best       = pick_right ? rdata : r_left;
    assign best_idx   = pick_right ? rc[ADDR_W-1:0] : lc[ADDR_W-1:0];

    always_comb begin
        o_flags.full           = (r_count >= CNT_W'(CAPACITY));
        o_flags.empty          = (r_count == '0);
        o_flags.pos_zero       = (r_pos == '0);
        o_flags.parent_greater = (rdata.urg > r_x.urg);
        o_flags.lc_out         = (lc >= count_x);
        o_flags.child_smaller  = (best.urg < r_x.urg);
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_pos;
        ram_wdata = r_x;
        ram_raddr = '0;
        if (i_cmd.rd_root) begin
            ram_raddr = '0;
        end
        if (i_cmd.rd_parent) begin
            ram_raddr = parent;
        end
        if (i_cmd.rd_last) begin
            ram_raddr = ADDR_W'(r_count - CNT_W'(1));
        end
        if (i_cmd.rd_left) begin
            ram_raddr = lc[ADDR_W-1:0];
        end
        if (i_cmd.rd_right) begin
            ram_raddr = rc[ADDR_W-1:0];
        end
        if (i_cmd.wr_x) begin
            ram_we = 1'b1;
        end
        if (i_cmd.wr_up) begin
            ram_we    = 1'b1;
            ram_wdata = rdata;
        end
        if (i_cmd.wr_child) begin
            ram_we    = 1'b1;
            ram_wdata = best;
        end
    end

    always_comb begin
        n_count  = r_count;
        n_pos    = r_pos;
        n_x      = r_x;
        n_top    = r_top;
        n_left   = r_left;
        n_strobe = i_cmd.finish;
        n_result = r_result;
        if (i_cmd.start_ins) begin
            n_x.id  = i_req.req_id;
            n_x.urg = i_req.urgency;
            n_pos   = ADDR_W'(r_count);
            n_count = r_count + CNT_W'(1);
        end
        if (i_cmd.wr_up) begin
            n_pos = parent;
        end
        if (i_cmd.rd_last) begin
            n_top = rdata;
        end
        if (i_cmd.ld_last) begin
            n_x     = rdata;
            n_pos   = '0;
            n_count = r_count - CNT_W'(1);
        end
        if (i_cmd.rd_right) begin
            n_left = rdata;
        end
        if (i_cmd.wr_child) begin
            n_pos = best_idx;
        end
        if (i_cmd.finish) begin
            n_result.status      = i_cmd.code;
            n_result.out_id      = (i_cmd.code == ST_EXTRACTED) ? r_top.id : '0;
            n_result.out_urgency = (i_cmd.code == ST_EXTRACTED) ? r_top.urg : '0;
            n_result.occupancy   = OCC_W'(r_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_count  <= n_count;
            r_strobe <= n_strobe;
        end
        r_pos    <= n_pos;
        r_x      <= n_x;
        r_top    <= n_top;
        r_left   <= n_left;
        r_result <= n_result;
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule

FILE: rtl/bmhq_ctrl.sv
// Controller of the heap queue: sequences insert sift-up and extract sift-down.
module bmhq_ctrl
    import bmhq_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_start,
    input  logic   i_req_type,
    input  t_flags i_flags,
    output t_cmd   o_cmd,
    output logic   o_busy
);

    typedef enum logic [7:0] {
        S_IDLE    = 8'b0000_0001,
        S_UP_RD   = 8'b0000_0010,
        S_UP_CMP  = 8'b0000_0100,
        S_EX_RD1  = 8'b0000_1000,
        S_EX_LAST = 8'b0001_0000,
        S_DN_RDL  = 8'b0010_0000,
        S_DN_RDR  = 8'b0100_0000,
        S_DN_CMP  = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    if (i_req_type == REQ_INSERT) begin
                        if (i_flags.full) begin
                            o_cmd.finish = 1'b1;
                            o_cmd.code   = ST_FULL;
                        end else begin
                            o_cmd.start_ins = 1'b1;
                            n_state         = S_UP_RD;
                        end
                    end else begin
                        if (i_flags.empty) begin
                            o_cmd.finish = 1'b1;
                            o_cmd.code   = ST_EMPTY;
                        end else begin
                            o_cmd.rd_root = 1'b1;
                            n_state       = S_EX_RD1;
                        end
                    end
                end
            end
            S_UP_RD: begin
                if (i_flags.pos_zero) begin
                    o_cmd.wr_x   = 1'b1;
                    o_cmd.finish = 1'b1;
                    o_cmd.code   = ST_INSERTED;
                    n_state      = S_IDLE;
                end else begin
                    o_cmd.rd_parent = 1'b1;
                    n_state         = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                if (i_flags.parent_greater) begin
                    o_cmd.wr_up = 1'b1;
                    n_state     = S_UP_RD;
                end else begin
                    o_cmd.wr_x   = 1'b1;
                    o_cmd.finish = 1'b1;
                    o_cmd.code   = ST_INSERTED;
                    n_state      = S_IDLE;
                end
            end
            S_EX_RD1: begin
                o_cmd.rd_last = 1'b1;
                n_state       = S_EX_LAST;
            end
            S_EX_LAST: begin
                o_cmd.ld_last = 1'b1;
                n_state       = S_DN_RDL;
            end
            S_DN_RDL: begin
                if (i_flags.lc_out) begin
                    o_cmd.wr_x   = 1'b1;
                    o_cmd.finish = 1'b1;
                    o_cmd.code   = ST_EXTRACTED;
                    n_state      = S_IDLE;
                end else begin
                    o_cmd.rd_left = 1'b1;
                    n_state       = S_DN_RDR;
                end
            end
            S_DN_RDR: begin
                o_cmd.rd_right = 1'b1;
                n_state        = S_DN_CMP;
            end
            S_DN_CMP: begin
                if (i_flags.child_smaller) begin
                    o_cmd.wr_child = 1'b1;
                    n_state        = S_DN_RDL;
                end else begin
                    o_cmd.wr_x   = 1'b1;
                    o_cmd.finish = 1'b1;
                    o_cmd.code   = ST_EXTRACTED;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

FILE: rtl/binary_min_heap_queue.sv
// Top level of the binary min-heap request queue.
//
//  channel   ports                         beat taken when
//  request   start, busy, i_req            start high and busy low at a clock edge
//  result    o_strobe, o_result            o_strobe high; receiver cannot stall
//
//  Insert holds busy while it sifts up and extract while it sifts down; at most 6
//  levels are walked for 64 entries; empty and full cases never raise busy.
//  The RAM has a single read port with registered data: one read per step.
//  The result beat appears in the cycle after the final heap write; a new beat may
//  be taken in that same cycle.
//  Reset clears the entry count and the controller; heap contents are left as is.
module binary_min_heap_queue
    import bmhq_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    input  t_req    i_req,
    output logic    busy,
    output logic    o_strobe,
    output t_result o_result
);

    t_cmd   cmd;
    t_flags flags;

    bmhq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_req_type (i_req.req_type),
        .i_flags    (flags),
        .o_cmd      (cmd),
        .o_busy     (busy)
    );

    bmhq_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (i_req),
        .i_cmd    (cmd),
        .o_flags  (flags),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy)
        else $error("result beat while busy");

    a_zero_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.status != ST_EXTRACTED) |->
            (o_result.out_id == '0 && o_result.out_urgency == '0))
        else $error("nonzero payload on non-extract beat");

    a_insert_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.status == ST_INSERTED) |-> (o_result.occupancy != '0))
        else $error("insert left queue empty");

    a_full_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.status == ST_FULL) |->
            (o_result.occupancy == OCC_W'(CAPACITY)))
        else $error("full status below capacity");

endmodule
